### hdl/indexed_doubly_linked_list_macros.svh
// Assertion helpers for the linked list block
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// Implication checked on every clock edge outside reset
`define IDLL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define IDLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/idll_pkg.sv
package idll_pkg;

  localparam int Capacity   = 256;
  localparam int SlotW      = $clog2(Capacity);
  localparam int CountW     = SlotW + 1;
  localparam int ValueW     = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT_AT  = 3'd2;
  localparam logic [2:0] OP_READ_AT    = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;
  localparam logic [2:0] OP_POP_BACK   = 3'd5;
  localparam logic [2:0] OP_DELETE_AT  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Memory select for the shared read port
  typedef enum logic [1:0] {
    RD_NEXT,
    RD_PREV,
    RD_VALUE,
    RD_FREE
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic [SlotW-1:0]  rd_addr;
    logic              wr_next;
    logic [SlotW-1:0]  wn_addr;
    logic [SlotW-1:0]  wn_data;
    logic              wr_prev;
    logic [SlotW-1:0]  wp_addr;
    logic [SlotW-1:0]  wp_data;
    logic              wr_value;
    logic [SlotW-1:0]  wv_addr;
    logic              wr_free;
    logic [SlotW-1:0]  wf_addr;
    logic [SlotW-1:0]  wf_data;
  } idll_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [SlotW-1:0]  rd_slot;
    logic [ValueW-1:0] rd_value;
  } idll_stat_t;

endpackage

### hdl/idll_datapath.sv
module idll_datapath
  import idll_pkg::*;
(
  input  logic              clk,
  input  idll_cmd_t         cmd,
  input  logic [ValueW-1:0] wv_data,
  output idll_stat_t        stat
);

  logic [ValueW-1:0] node_values [Capacity];
  logic [SlotW-1:0]  next_links  [Capacity];
  logic [SlotW-1:0]  prev_links  [Capacity];
  logic [SlotW-1:0]  free_slots  [Capacity];
  logic [SlotW-1:0]  nx_q, pv_q, fr_q;
  logic [ValueW-1:0] val_q;
  rd_sel_t           sel_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_value) node_values[cmd.wv_addr] <= wv_data;
    val_q <= node_values[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_next) next_links[cmd.wn_addr] <= cmd.wn_data;
    nx_q <= next_links[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_prev) prev_links[cmd.wp_addr] <= cmd.wp_data;
    pv_q <= prev_links[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_free) free_slots[cmd.wf_addr] <= cmd.wf_data;
    fr_q <= free_slots[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) sel_q <= cmd.rd_sel;
  end

  always_comb begin
    stat.rd_value = val_q;
    case (sel_q)
      RD_NEXT: stat.rd_slot = nx_q;
      RD_PREV: stat.rd_slot = pv_q;
      RD_FREE: stat.rd_slot = fr_q;
      default: stat.rd_slot = nx_q;
    endcase
  end

endmodule

### hdl/idll_ctrl.sv
module idll_ctrl
  import idll_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op_in,
  input  logic [CountW-1:0] pos_in,
  input  logic [ValueW-1:0] val_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] read_value,
  output logic [1:0]        status,
  output logic [CountW-1:0] entry_count,
  output logic [ValueW-1:0] wv_data,
  output idll_cmd_t         cmd,
  input  idll_stat_t        stat
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FREE_RD, S_FREE_WT, S_LINK, S_WALK, S_WALK_WT,
    S_AT, S_UNL_P, S_UNL_N, S_UNL_DO, S_RDVAL, S_RDVAL_WT, S_DONE
  } state_t;

  state_t            state;
  logic [2:0]        op;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] walk_cnt;
  logic [CountW-1:0] free_top;
  logic [CountW-1:0] count;
  logic [SlotW-1:0]  head_slot, tail_slot;
  logic [SlotW-1:0]  new_slot, cur, nbr_p, nbr_n, succ;
  logic [SlotW-1:0]  init_idx;
  logic              full;
  state_t            state_next;
  logic [2:0]        op_next;
  logic [1:0]        status_next;
  logic [ValueW-1:0] read_value_next;
  logic [SlotW-1:0]  cur_next;

  assign full     = (count == CountW'(Capacity)) || (free_top == '0);
  assign in_ready = (state == S_IDLE) && !out_valid;

  // Decode of an incoming request
  always_comb begin
    state_next      = S_DONE;
    op_next         = op_in;
    status_next     = ST_OK;
    read_value_next = '0;
    cur_next        = head_slot;
    case (op_in)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) status_next = ST_FULL;
        else state_next = S_FREE_RD;
      end
      OP_INSERT_AT: begin
        if (pos_in > count) status_next = ST_BOUND;
        else if (full) status_next = ST_FULL;
        else begin
          state_next = S_FREE_RD;
          if (pos_in == '0) op_next = OP_PUSH_FRONT;
          else if (pos_in == count) op_next = OP_PUSH_BACK;
        end
      end
      OP_READ_AT: begin
        if (pos_in >= count) begin
          status_next     = ST_BOUND;
          read_value_next = '1;
        end else state_next = S_WALK;
      end
      OP_POP_FRONT: begin
        if (count == '0) status_next = ST_EMPTY;
        else state_next = S_UNL_P;
      end
      OP_POP_BACK: begin
        cur_next = tail_slot;
        if (count == '0) status_next = ST_EMPTY;
        else state_next = S_UNL_P;
      end
      OP_DELETE_AT: begin
        if (pos_in >= count) status_next = ST_BOUND;
        else state_next = S_WALK;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_NEXT;
    case (state)
      S_INIT: begin
        cmd.wr_free = 1'b1;
        cmd.wf_addr = init_idx;
        cmd.wf_data = init_idx;
      end
      S_FREE_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_FREE;
        cmd.rd_addr = SlotW'(free_top - 1'b1);
      end
      S_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_NEXT;
        cmd.rd_addr = cur;
      end
      S_UNL_P: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_PREV;
        cmd.rd_addr = cur;
      end
      S_UNL_N: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_NEXT;
        cmd.rd_addr = cur;
      end
      S_RDVAL: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_VALUE;
        cmd.rd_addr = cur;
      end
      S_LINK: begin
        cmd.wr_value = 1'b1;
        cmd.wv_addr  = new_slot;
        cmd.wr_next  = 1'b1;
        cmd.wn_addr  = new_slot;
        cmd.wr_prev  = 1'b1;
        cmd.wp_addr  = new_slot;
        // Link the old end node back to the new one
        if (op == OP_PUSH_FRONT && count != '0) begin
          cmd.wn_data = head_slot;
          cmd.wp_addr = head_slot;
          cmd.wp_data = new_slot;
        end else if (op == OP_PUSH_BACK && count != '0) begin
          cmd.wp_data = tail_slot;
          cmd.wn_addr = tail_slot;
          cmd.wn_data = new_slot;
        end
      end
      S_WALK_WT: begin
        // cur is the node before the insert point, stat.rd_slot its successor
        if (op == OP_INSERT_AT && walk_cnt == '1) begin
          cmd.wr_next = 1'b1;
          cmd.wn_addr = cur;
          cmd.wn_data = new_slot;
          cmd.wr_prev = 1'b1;
          cmd.wp_addr = stat.rd_slot;
          cmd.wp_data = new_slot;
        end
      end
      S_AT: begin
        if (op == OP_INSERT_AT) begin
          cmd.wr_next = 1'b1;
          cmd.wn_addr = new_slot;
          cmd.wn_data = succ;
          cmd.wr_prev = 1'b1;
          cmd.wp_addr = new_slot;
          cmd.wp_data = cur;
        end
      end
      S_UNL_DO: begin
        if (count > CountW'(1)) begin
          if (cur != head_slot) begin
            cmd.wr_next = 1'b1;
            cmd.wn_addr = nbr_p;
            cmd.wn_data = nbr_n;
          end
          if (cur != tail_slot) begin
            cmd.wr_prev = 1'b1;
            cmd.wp_addr = nbr_n;
            cmd.wp_data = nbr_p;
          end
        end
        cmd.wr_free = (free_top < CountW'(Capacity));
        cmd.wf_addr = SlotW'(free_top);
        cmd.wf_data = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      free_top  <= CountW'(Capacity);
      count     <= '0;
      head_slot <= '0;
      tail_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == SlotW'(Capacity - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op         <= op_next;
            pos        <= pos_in;
            wv_data    <= val_in;
            read_value <= read_value_next;
            status     <= status_next;
            cur        <= cur_next;
            walk_cnt   <= '0;
            state      <= state_next;
          end
        end
        S_FREE_RD: state <= S_FREE_WT;
        S_FREE_WT: begin
          new_slot <= stat.rd_slot;
          free_top <= free_top - 1'b1;
          state    <= S_LINK;
        end
        S_LINK: begin
          count <= count + 1'b1;
          if (op == OP_PUSH_FRONT) begin
            head_slot <= new_slot;
            if (count == '0) tail_slot <= new_slot;
            state <= S_AT;
          end else if (op == OP_PUSH_BACK) begin
            tail_slot <= new_slot;
            if (count == '0) head_slot <= new_slot;
            state <= S_AT;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // insert walks to pos-1 then reads the successor; the others walk to pos
          if ((op == OP_INSERT_AT) ? (walk_cnt == pos - 1'b1) : (walk_cnt == pos)) begin
            if (op == OP_READ_AT) state <= S_RDVAL;
            else if (op == OP_DELETE_AT) state <= S_UNL_P;
            else state <= S_WALK_WT;
            walk_cnt <= '1;
          end else state <= S_WALK_WT;
        end
        S_WALK_WT: begin
          if (walk_cnt == '1) begin
            succ  <= stat.rd_slot;
            state <= S_AT;
          end else begin
            cur      <= stat.rd_slot;
            walk_cnt <= walk_cnt + 1'b1;
            state    <= S_WALK;
          end
        end
        S_AT: state <= S_DONE;
        S_UNL_P: state <= S_UNL_N;
        S_UNL_N: begin
          nbr_p <= stat.rd_slot;
          state <= S_UNL_DO;
        end
        S_UNL_DO: begin
          if (count <= CountW'(1)) begin
            head_slot <= '0;
            tail_slot <= '0;
          end else begin
            if (cur == head_slot) head_slot <= stat.rd_slot;
            if (cur == tail_slot) tail_slot <= nbr_p;
          end
          if (free_top < CountW'(Capacity)) free_top <= free_top + 1'b1;
          count <= count - 1'b1;
          state <= S_DONE;
        end
        S_RDVAL: state <= S_RDVAL_WT;
        S_RDVAL_WT: begin
          read_value <= stat.rd_value;
          state      <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // In S_UNL_DO the next link arrives straight from the read port
  always_comb nbr_n = stat.rd_slot;

  assign entry_count = count;

endmodule

### hdl/indexed_doubly_linked_list.sv
// Indexed doubly linked list of signed 32-bit values, 256 entries.
// Request channel s_axis: tdata carries opcode, position and item_value; a
// beat is taken when s_axis_tvalid and s_axis_tready are both high. Each
// request returns exactly one beat on m_axis: read_value, status, entry_count.
// One request is in flight at a time; s_axis_tready is high only when the
// controller is idle and the previous result has been taken.
// A rejected or unused request goes straight to S_DONE; pop reads the prev
// and next links of the node and unlinks it; push takes a slot from the free
// stack and links it in. Indexed requests walk the next links from the head
// one node at a time, and the single read port of the link memories paces
// this walk. A new request is taken in the cycle after the result beat is
// taken. Reset (rst, synchronous) empties the list and then fills the
// free-slot stack in a pass over all 256 slots; no request is taken during
// that pass. When m_axis_tready is low the result is held and no new
// request is taken.
module indexed_doubly_linked_list
  import idll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // opcode[2:0], position[11:3], item_value[43:12], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_value[31:0], status[33:32], entry_count[42:34], zero
);

`include "indexed_doubly_linked_list_macros.svh"

  idll_cmd_t         cmd;
  idll_stat_t        stat;
  logic [ValueW-1:0] read_value;
  logic [1:0]        status;
  logic [CountW-1:0] entry_count;
  logic [ValueW-1:0] wv_data;

  idll_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .op_in       (s_axis_tdata[2:0]),
    .pos_in      (s_axis_tdata[11:3]),
    .val_in      (s_axis_tdata[43:12]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .wv_data     (wv_data),
    .cmd         (cmd),
    .stat        (stat)
  );

  idll_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .wv_data (wv_data),
    .stat    (stat)
  );

  assign m_axis_tdata = {5'd0, entry_count, status, read_value};

  `IDLL_ASSERT_IMPL(a_no_take_while_out, m_axis_tvalid, !s_axis_tready)
  `IDLL_ASSERT_IMPL(a_count_range, 1'b1, entry_count <= CountW'(Capacity))
  `IDLL_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

### test/indexed_doubly_linked_list_tb.sv
module indexed_doubly_linked_list_tb
  import idll_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [8:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [8:0]  entry_count;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  indexed_doubly_linked_list u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // List contents in order, front first
  logic [31:0] shadow_list[$];
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int          mismatches = 0;
  int          sent_count = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int n;
    n = shadow_list.size();
    o.read_value = '0;
    o.status = ST_OK;
    case (r.opcode)
      OP_PUSH_FRONT: if (n >= Capacity) o.status = ST_FULL;
                     else shadow_list.push_front(r.item_value);
      OP_PUSH_BACK:  if (n >= Capacity) o.status = ST_FULL;
                     else shadow_list.push_back(r.item_value);
      OP_INSERT_AT: begin
        if (r.position > n) o.status = ST_BOUND;
        else if (n >= Capacity) o.status = ST_FULL;
        else shadow_list.insert(r.position, r.item_value);
      end
      OP_READ_AT: begin
        if (r.position >= n) begin
          o.status = ST_BOUND;
          o.read_value = '1;
        end else o.read_value = shadow_list[r.position];
      end
      OP_POP_FRONT: if (n == 0) o.status = ST_EMPTY;
                    else void'(shadow_list.pop_front());
      OP_POP_BACK:  if (n == 0) o.status = ST_EMPTY;
                    else void'(shadow_list.pop_back());
      OP_DELETE_AT: if (r.position >= n) o.status = ST_BOUND;
                    else shadow_list.delete(r.position);
      default: ;
    endcase
    o.entry_count = 9'(shadow_list.size());
    return o;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Track length as the stimulus is generated to pick useful positions
  int gen_len = 0;

  task automatic add_req(logic [2:0] op, logic [8:0] pos, logic [31:0] v);
    req_t r;
    r.opcode = op; r.position = pos; r.item_value = v;
    pending_reqs.push_back(r);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_len < Capacity) gen_len++;
      OP_INSERT_AT: if (pos <= gen_len && gen_len < Capacity) gen_len++;
      OP_POP_FRONT, OP_POP_BACK: if (gen_len > 0) gen_len--;
      OP_DELETE_AT: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic add_random(int fill_bias);
    logic [2:0] op;
    logic [8:0] pos;
    int k;
    k = $urandom_range(0, 99);
    if (k < fill_bias) op = 3'($urandom_range(0, 2));
    else if (k < 70) op = ($urandom_range(0, 1) != 0) ? OP_READ_AT : OP_INSERT_AT;
    else if (k < 97) op = 3'($urandom_range(4, 6));
    else op = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) pos = 9'($urandom_range(0, 511));
    else if (gen_len == 0) pos = 0;
    else pos = 9'($urandom_range(0, gen_len));
    add_req(op, pos, rand_value());
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() != 0 && !hold_off && (calm || $urandom_range(0, 99) >= 20)) begin
        req_t r;
        r = pending_reqs.pop_front();
        s_axis_tdata <= {4'd0, r.item_value, r.position, r.opcode};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      req_t r;
      r.opcode = s_axis_tdata[2:0];
      r.position = s_axis_tdata[11:3];
      r.item_value = s_axis_tdata[43:12];
      expected_rsps.push_back(apply_request(r));
      sent_count++;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rsp_t got, want;
      got.read_value = m_axis_tdata[31:0];
      got.status = m_axis_tdata[33:32];
      got.entry_count = m_axis_tdata[42:34];
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rd=%h st=%0d cnt=%0d got rd=%h st=%0d cnt=%0d",
                     want.read_value, want.status, want.entry_count,
                     got.read_value, got.status, got.entry_count);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, bounds, extremes
    add_req(OP_POP_FRONT, 0, 0);
    add_req(OP_POP_BACK, 0, 0);
    add_req(OP_READ_AT, 0, 0);
    add_req(OP_DELETE_AT, 0, 0);
    add_req(OP_INSERT_AT, 1, 32'h1234_5678);
    add_req(OP_INSERT_AT, 0, 32'h8000_0000);
    add_req(OP_PUSH_FRONT, 0, 32'h7fff_ffff);
    add_req(OP_PUSH_BACK, 9'h1ff, 32'hffff_ffff);
    add_req(OP_INSERT_AT, 1, 32'h5555_aaaa);
    add_req(OP_INSERT_AT, 4, 32'haaaa_5555);
    add_req(OP_READ_AT, 0, 0);
    add_req(OP_READ_AT, 4, 0);
    add_req(OP_READ_AT, 5, 0);
    add_req(OP_READ_AT, 9'h1ff, 0);
    add_req(OP_UNUSED, 9'h155, 32'hdead_beef);
    add_req(OP_DELETE_AT, 2, 0);
    add_req(OP_DELETE_AT, 5, 0);
    add_req(OP_POP_FRONT, 0, 0);
    add_req(OP_POP_BACK, 0, 0);
    add_req(OP_DELETE_AT, 0, 0);
    add_req(OP_DELETE_AT, 0, 0);
    add_req(OP_POP_BACK, 0, 0);
    wait_drained();

    // Pause the sender mid-stream until the list block has answered everything
    for (int i = 0; i < 40; i++) add_random(30);
    repeat (60) @(posedge clk);
    hold_off = 1'b1;
    while (s_axis_tvalid || expected_rsps.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;

    // Mixed traffic on a short list
    for (int i = 0; i < 560; i++) add_random(30);
    wait_drained();

    // Fill to capacity, hit full and the last index, then drain
    calm = 1'b1;
    while (gen_len < Capacity) add_req(3'($urandom_range(0, 2)), 0, $urandom());
    add_req(OP_PUSH_FRONT, 0, 1);
    add_req(OP_PUSH_BACK, 0, 2);
    add_req(OP_INSERT_AT, 9'(Capacity), 3);
    add_req(OP_INSERT_AT, 9'd100, 4);
    add_req(OP_READ_AT, 9'(Capacity - 1), 0);
    add_req(OP_READ_AT, 9'(Capacity), 0);
    add_req(OP_DELETE_AT, 9'(Capacity - 1), 0);
    add_req(OP_INSERT_AT, 9'(Capacity - 1), 5);
    wait_drained();
    calm = 1'b0;
    for (int i = 0; i < 300; i++) add_random(20);
    while (gen_len > 0) add_req(3'($urandom_range(4, 6)), 0, 0);
    wait_drained();

    for (int i = 0; i < 300; i++) add_random(40);
    wait_drained();
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule

### indexed_doubly_linked_list.f
+incdir+hdl
hdl/idll_pkg.sv
hdl/idll_datapath.sv
hdl/idll_ctrl.sv
hdl/indexed_doubly_linked_list.sv
test/indexed_doubly_linked_list_tb.sv
